// ===== rtl/core/ppna_pkg.sv =====
// Shared types, microcode field codes and constants for the point-to-plane accumulator.
package ppna_pkg;

  localparam int NUM_SUMS = 27;
  localparam int NUM_TRI  = 21;
  localparam int NUM_ROWS = 6;
  localparam int NRM_W    = 18;
  localparam int ACC_W    = 64;
  localparam int JW       = 32;
  localparam int IDX_W    = 5;
  localparam int PC_W     = 6;
  localparam int SRC_W    = 4;
  localparam int OP_W     = 3;
  localparam int RND_W    = 3;
  localparam int SEQ_W    = 2;

  localparam logic [IDX_W-1:0] TRI_ROW_BASE [NUM_ROWS] = '{
    5'd0, 5'd6, 5'd11, 5'd15, 5'd18, 5'd20
  };
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SUMS - 1);
  localparam logic [IDX_W-1:0] RJ_BASE  = IDX_W'(NUM_TRI);

  // operand sources; J0..J2 then N0..N2 form the six Jacobian entries in order
  localparam logic [SRC_W-1:0] SRC_J0 = 4'd0;
  localparam logic [SRC_W-1:0] SRC_J1 = 4'd1;
  localparam logic [SRC_W-1:0] SRC_J2 = 4'd2;
  localparam logic [SRC_W-1:0] SRC_N0 = 4'd3;
  localparam logic [SRC_W-1:0] SRC_N1 = 4'd4;
  localparam logic [SRC_W-1:0] SRC_N2 = 4'd5;
  localparam logic [SRC_W-1:0] SRC_R  = 4'd6;
  localparam logic [SRC_W-1:0] SRC_D0 = 4'd7;
  localparam logic [SRC_W-1:0] SRC_D1 = 4'd8;
  localparam logic [SRC_W-1:0] SRC_D2 = 4'd9;
  localparam logic [SRC_W-1:0] SRC_X0 = 4'd10;
  localparam logic [SRC_W-1:0] SRC_X1 = 4'd11;
  localparam logic [SRC_W-1:0] SRC_X2 = 4'd12;

  localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
  localparam logic [OP_W-1:0] OP_TLOAD = 3'd1;
  localparam logic [OP_W-1:0] OP_TADD  = 3'd2;
  localparam logic [OP_W-1:0] OP_TSUB  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUM   = 3'd4;

  localparam logic [RND_W-1:0] RND_NONE = 3'd0;
  localparam logic [RND_W-1:0] RND_R    = 3'd1;
  localparam logic [RND_W-1:0] RND_J0   = 3'd2;
  localparam logic [RND_W-1:0] RND_J1   = 3'd3;
  localparam logic [RND_W-1:0] RND_J2   = 3'd4;

  localparam logic [SEQ_W-1:0] SEQ_NEXT = 2'd0;
  localparam logic [SEQ_W-1:0] SEQ_WAIT = 2'd1;
  localparam logic [SEQ_W-1:0] SEQ_END  = 2'd2;
  localparam logic [SEQ_W-1:0] SEQ_EMIT = 2'd3;

  localparam logic [PC_W-1:0] PC_IDLE  = 6'd0;
  localparam logic [PC_W-1:0] PC_MATCH = 6'd1;
  localparam logic [PC_W-1:0] PC_SUMS  = 6'd12;
  localparam logic [PC_W-1:0] PC_END   = 6'd39;
  localparam logic [PC_W-1:0] PC_EMIT  = 6'd40;

  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic [PC_W-1:0]  jmp;
    logic [SRC_W-1:0] a_sel;
    logic [SRC_W-1:0] b_sel;
    logic [OP_W-1:0]  op;
    logic [IDX_W-1:0] k;
    logic [RND_W-1:0] rnd;
  } ctl_word_t;

  typedef struct packed {
    logic             acc_en;
    logic             clr_en;
    logic [IDX_W-1:0] addr;
  } acc_cmd_t;

endpackage

// ===== rtl/core/ppna_ifs.sv =====
// Valid/ready channel interfaces for point beats and sum beats.
interface ppna_in_if import ppna_pkg::*; #(parameter int COORD_WIDTH = 24) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] src_x;
  logic signed [COORD_WIDTH-1:0] src_y;
  logic signed [COORD_WIDTH-1:0] src_z;
  logic signed [COORD_WIDTH-1:0] tgt_x;
  logic signed [COORD_WIDTH-1:0] tgt_y;
  logic signed [COORD_WIDTH-1:0] tgt_z;
  logic signed [NRM_W-1:0]       nrm_x;
  logic signed [NRM_W-1:0]       nrm_y;
  logic signed [NRM_W-1:0]       nrm_z;
  logic                          has_match;
  logic                          last_point;

  modport source (
    output valid, src_x, src_y, src_z, tgt_x, tgt_y, tgt_z,
           nrm_x, nrm_y, nrm_z, has_match, last_point,
    input  ready
  );
  modport sink (
    input  valid, src_x, src_y, src_z, tgt_x, tgt_y, tgt_z,
           nrm_x, nrm_y, nrm_z, has_match, last_point,
    output ready
  );
endinterface

interface ppna_out_if import ppna_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        entry_index;
  logic signed [ACC_W-1:0] entry_value;
  logic                    last_entry;

  modport source (output valid, entry_index, entry_value, last_entry, input ready);
  modport sink (input valid, entry_index, entry_value, last_entry, output ready);
endinterface

// ===== rtl/core/ppna_ucode_rom.sv =====
// Microcode ROM: one control word per program step.
module ppna_ucode_rom import ppna_pkg::*; (
  input  logic [PC_W-1:0] pc,
  output ctl_word_t       word
);

  function automatic ctl_word_t cw(input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                   input logic [OP_W-1:0] op, input logic [RND_W-1:0] rnd);
    ctl_word_t w;
    w       = '0;
    w.seq   = SEQ_NEXT;
    w.a_sel = a;
    w.b_sel = b;
    w.op    = op;
    w.rnd   = rnd;
    return w;
  endfunction

  logic [2:0]       row;
  logic [IDX_W-1:0] k;
  logic [IDX_W-1:0] col;

  always_comb begin
    row  = 3'd0;
    k    = IDX_W'(pc - PC_SUMS);
    col  = '0;
    word = cw(SRC_J0, SRC_J0, OP_NONE, RND_NONE);
    if (pc >= PC_SUMS && pc < PC_END) begin
      if (k < RJ_BASE) begin
        for (int i = 0; i < NUM_ROWS; i++) begin
          if (k >= TRI_ROW_BASE[i]) row = 3'(i);
        end
        col  = IDX_W'(row) + (k - TRI_ROW_BASE[row]);
        word = cw(SRC_J0 + SRC_W'(row), SRC_J0 + SRC_W'(col), OP_SUM, RND_NONE);
      end else begin
        word = cw(SRC_J0 + SRC_W'(k - RJ_BASE), SRC_R, OP_SUM, RND_NONE);
      end
      word.k = k;
    end else begin
      unique case (pc)
        PC_IDLE: begin
          word.seq = SEQ_WAIT;
          word.jmp = PC_EMIT;
        end
        6'd1:    word = cw(SRC_N0, SRC_D0, OP_TLOAD, RND_NONE);
        6'd2:    word = cw(SRC_N1, SRC_D1, OP_TADD, RND_NONE);
        6'd3:    word = cw(SRC_N2, SRC_D2, OP_TADD, RND_NONE);
        6'd4:    word = cw(SRC_X1, SRC_N2, OP_TLOAD, RND_NONE);
        6'd5:    word = cw(SRC_X2, SRC_N1, OP_TSUB, RND_R);
        6'd6:    word = cw(SRC_X2, SRC_N0, OP_TLOAD, RND_NONE);
        6'd7:    word = cw(SRC_X0, SRC_N2, OP_TSUB, RND_J0);
        6'd8:    word = cw(SRC_X0, SRC_N1, OP_TLOAD, RND_NONE);
        6'd9:    word = cw(SRC_X1, SRC_N0, OP_TSUB, RND_J1);
        6'd10:   word = cw(SRC_J0, SRC_J0, OP_NONE, RND_NONE);
        6'd11:   word = cw(SRC_J0, SRC_J0, OP_NONE, RND_J2);
        PC_END: begin
          word.seq = SEQ_END;
          word.jmp = PC_EMIT;
        end
        PC_EMIT: word.seq = SEQ_EMIT;
        default: word = cw(SRC_J0, SRC_J0, OP_NONE, RND_NONE);
      endcase
    end
  end

endmodule

// ===== rtl/core/ppna_datapath.sv =====
// Point registers, shared multiplier, term accumulator and round/saturate to Q.F.
module ppna_datapath import ppna_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          ld,
  input  logic signed [COORD_WIDTH-1:0] src_x,
  input  logic signed [COORD_WIDTH-1:0] src_y,
  input  logic signed [COORD_WIDTH-1:0] src_z,
  input  logic signed [COORD_WIDTH-1:0] tgt_x,
  input  logic signed [COORD_WIDTH-1:0] tgt_y,
  input  logic signed [COORD_WIDTH-1:0] tgt_z,
  input  logic signed [NRM_W-1:0]       nrm_x,
  input  logic signed [NRM_W-1:0]       nrm_y,
  input  logic signed [NRM_W-1:0]       nrm_z,
  input  ctl_word_t                     ctl,
  input  logic [OP_W-1:0]               op_d,
  output logic signed [ACC_W-1:0]       prod
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = (DW > JW) ? DW : JW;

  logic signed [COORD_WIDTH-1:0] x_r [3];
  logic signed [DW-1:0]          d_r [3];
  logic signed [NRM_W-1:0]       n_r [3];
  logic signed [JW-1:0]          j_r [3];
  logic signed [JW-1:0]          r_r;
  logic signed [ACC_W-1:0]       t_r;
  logic signed [ACC_W-1:0]       t_nxt;
  logic signed [ACC_W-1:0]       p_r;
  logic signed [MW-1:0]          op_a;
  logic signed [MW-1:0]          op_b;
  logic signed [2*MW-1:0]        mul;
  logic signed [ACC_W-1:0]       rnd_sum;
  logic signed [ACC_W-1:0]       rnd_sh;
  logic signed [JW-1:0]          rnd_q;

  function automatic logic signed [MW-1:0] pick(
    input logic [SRC_W-1:0] sel,
    input logic signed [COORD_WIDTH-1:0] x0, input logic signed [COORD_WIDTH-1:0] x1,
    input logic signed [COORD_WIDTH-1:0] x2,
    input logic signed [DW-1:0] d0, input logic signed [DW-1:0] d1,
    input logic signed [DW-1:0] d2,
    input logic signed [NRM_W-1:0] n0, input logic signed [NRM_W-1:0] n1,
    input logic signed [NRM_W-1:0] n2,
    input logic signed [JW-1:0] j0, input logic signed [JW-1:0] j1,
    input logic signed [JW-1:0] j2, input logic signed [JW-1:0] r);
    logic signed [MW-1:0] v;
    case (sel)
      SRC_J0:  v = MW'(j0);
      SRC_J1:  v = MW'(j1);
      SRC_J2:  v = MW'(j2);
      SRC_N0:  v = MW'(n0);
      SRC_N1:  v = MW'(n1);
      SRC_N2:  v = MW'(n2);
      SRC_R:   v = MW'(r);
      SRC_D0:  v = MW'(d0);
      SRC_D1:  v = MW'(d1);
      SRC_D2:  v = MW'(d2);
      SRC_X0:  v = MW'(x0);
      SRC_X1:  v = MW'(x1);
      SRC_X2:  v = MW'(x2);
      default: v = '0;
    endcase
    return v;
  endfunction

  assign op_a = pick(ctl.a_sel, x_r[0], x_r[1], x_r[2], d_r[0], d_r[1], d_r[2],
                     n_r[0], n_r[1], n_r[2], j_r[0], j_r[1], j_r[2], r_r);
  assign op_b = pick(ctl.b_sel, x_r[0], x_r[1], x_r[2], d_r[0], d_r[1], d_r[2],
                     n_r[0], n_r[1], n_r[2], j_r[0], j_r[1], j_r[2], r_r);
  assign mul  = op_a * op_b;
  assign prod = p_r;

  always_comb begin
    case (op_d)
      OP_TLOAD: t_nxt = p_r;
      OP_TADD:  t_nxt = t_r + p_r;
      OP_TSUB:  t_nxt = t_r - p_r;
      default:  t_nxt = t_r;
    endcase
  end

  assign rnd_sum = t_r + (64'sd1 <<< (FRAC_BITS - 1));
  assign rnd_sh  = rnd_sum >>> FRAC_BITS;

  always_comb begin
    if (rnd_sh > 64'sd2147483647) begin
      rnd_q = 32'sh7fffffff;
    end else if (rnd_sh < -64'sd2147483648) begin
      rnd_q = 32'sh80000000;
    end else begin
      rnd_q = JW'(rnd_sh);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      x_r[0] <= src_x;
      x_r[1] <= src_y;
      x_r[2] <= src_z;
      d_r[0] <= DW'(src_x) - DW'(tgt_x);
      d_r[1] <= DW'(src_y) - DW'(tgt_y);
      d_r[2] <= DW'(src_z) - DW'(tgt_z);
      n_r[0] <= nrm_x;
      n_r[1] <= nrm_y;
      n_r[2] <= nrm_z;
    end
    p_r <= mul[ACC_W-1:0];
    t_r <= t_nxt;
    case (ctl.rnd)
      RND_R:   r_r    <= rnd_q;
      RND_J0:  j_r[0] <= rnd_q;
      RND_J1:  j_r[1] <= rnd_q;
      RND_J2:  j_r[2] <= rnd_q;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/ppna_acc_bank.sv =====
// Bank of 27 saturating 64-bit sums with per-entry valid flags.
module ppna_acc_bank import ppna_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  acc_cmd_t                cmd,
  input  logic signed [ACC_W-1:0] prod,
  output logic signed [ACC_W-1:0] rd_data
);

  logic signed [ACC_W-1:0] sum_r [NUM_SUMS];
  logic [NUM_SUMS-1:0]     vld_r;
  logic [ACC_W:0]          add_w;
  logic signed [ACC_W-1:0] sat_w;

  assign rd_data = vld_r[cmd.addr] ? sum_r[cmd.addr] : '0;
  assign add_w   = {rd_data[ACC_W-1], rd_data} + {prod[ACC_W-1], prod};

  always_comb begin
    if (add_w[ACC_W] != add_w[ACC_W-1]) begin
      sat_w = add_w[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_w = add_w[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.acc_en) begin
      vld_r[cmd.addr] <= 1'b1;
    end else if (cmd.clr_en) begin
      vld_r[cmd.addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      sum_r[cmd.addr] <= sat_w;
    end
  end

endmodule

// ===== rtl/core/point_to_plane_normal_accumulate_unit.sv =====
// Top level: microcode sequencer, datapath, sum bank and output register.
// Matched point: the microprogram runs to its end before the next point can be taken.
// Unmatched point that is not last: the sequencer stays idle and can take the next point.
// Last point: 27 sum beats follow once the microprogram ends (matched) or straight
// after accept (unmatched), one per cycle when the sink keeps ready high.
// All microprogram steps share the one multiplier.
// Reset clears the sequencer, output valid and the sum valid flags: all sums read zero.
module point_to_plane_normal_accumulate_unit import ppna_pkg::*; #(
  parameter int COORD_WIDTH = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  ppna_in_if.sink     in_ch,
  ppna_out_if.source  out_ch
);

  logic [PC_W-1:0]         pc_r;
  logic [PC_W-1:0]         pc_nxt;
  logic [IDX_W-1:0]        e_r;
  logic [IDX_W-1:0]        e_nxt;
  logic                    last_r;
  ctl_word_t               ctl;
  ctl_word_t               ctl_d_r;
  acc_cmd_t                acc_cmd;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] rd_data;
  logic                    accept;
  logic                    emit_ld;
  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [ACC_W-1:0] out_val_r;
  logic                    out_last_r;

  ppna_ucode_rom u_rom (
    .pc   (pc_r),
    .word (ctl)
  );

  ppna_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk   (clk),
    .ld    (accept),
    .src_x (in_ch.src_x),
    .src_y (in_ch.src_y),
    .src_z (in_ch.src_z),
    .tgt_x (in_ch.tgt_x),
    .tgt_y (in_ch.tgt_y),
    .tgt_z (in_ch.tgt_z),
    .nrm_x (in_ch.nrm_x),
    .nrm_y (in_ch.nrm_y),
    .nrm_z (in_ch.nrm_z),
    .ctl   (ctl),
    .op_d  (ctl_d_r.op),
    .prod  (prod)
  );

  ppna_acc_bank u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (acc_cmd),
    .prod    (prod),
    .rd_data (rd_data)
  );

  assign in_ch.ready = (ctl.seq == SEQ_WAIT);
  assign accept      = in_ch.valid && in_ch.ready;
  assign emit_ld     = (ctl.seq == SEQ_EMIT) && (!out_valid_r || out_ch.ready);

  assign acc_cmd.acc_en = (ctl_d_r.op == OP_SUM);
  assign acc_cmd.clr_en = emit_ld;
  assign acc_cmd.addr   = (ctl.seq == SEQ_EMIT) ? e_r : ctl_d_r.k;

  always_comb begin
    pc_nxt = pc_r;
    e_nxt  = e_r;
    unique case (ctl.seq)
      SEQ_WAIT: begin
        if (accept) begin
          if (in_ch.has_match) begin
            pc_nxt = PC_MATCH;
          end else if (in_ch.last_point) begin
            pc_nxt = ctl.jmp;
          end
        end
      end
      SEQ_NEXT: pc_nxt = pc_r + 1'b1;
      SEQ_END:  pc_nxt = last_r ? ctl.jmp : PC_IDLE;
      SEQ_EMIT: begin
        if (emit_ld) begin
          if (e_r == LAST_IDX) begin
            e_nxt  = '0;
            pc_nxt = PC_IDLE;
          end else begin
            e_nxt = e_r + 1'b1;
          end
        end
      end
      default: pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      e_r         <= '0;
      ctl_d_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r    <= pc_nxt;
      e_r     <= e_nxt;
      ctl_d_r <= ctl;
      if (emit_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_ch.last_point;
    end
    if (emit_ld) begin
      out_idx_r  <= e_r;
      out_val_r  <= rd_data;
      out_last_r <= (e_r == LAST_IDX);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.entry_index = out_idx_r;
  assign out_ch.entry_value = out_val_r;
  assign out_ch.last_entry  = out_last_r;

  a_no_acc_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc_cmd.acc_en && emit_ld))
    else $error("sum update during emission");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> ctl_d_r.op == OP_NONE)
    else $error("pending sum update while taking a new beat");

  a_last_beat_idx: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld && e_r == LAST_IDX |=> pc_r == PC_IDLE && out_last_r)
    else $error("emission did not end on the last entry");

  a_emit_order: assert property (@(posedge clk) disable iff (!rst_n)
    emit_ld && e_r != LAST_IDX |=> e_r == $past(e_r) + 1'b1 && !out_last_r)
    else $error("emission index skipped");

endmodule
